// File: hdl/mrdm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mrdm_pkg;

	localparam int SAMPLE_WIDTH_DEF  = 32;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int COUNT_WIDTH_DEF   = 20;

	// Command from the sequencer to the accumulator.
	typedef struct packed {
		logic add;
		logic last;
	} mrdm_cmd_t;

	// Status from the accumulator back to the sequencer.
	typedef struct packed {
		logic done;
		logic error;
	} mrdm_stat_t;

endpackage

`default_nettype wire

// File: hdl/mrdm_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mrdm_in_if #(
	parameter int SAMPLE_WIDTH = 32
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] ref_sample;
	logic signed [SAMPLE_WIDTH-1:0] eval_sample;
	logic                           last_item;

	modport source (output valid, output ref_sample, output eval_sample, output last_item,
		input ready);
	modport sink (input valid, input ref_sample, input eval_sample, input last_item,
		output ready);
endinterface

interface mrdm_out_if #(
	parameter int FRACTION_BITS = 16
);
	logic                     valid;
	logic                     ready;
	logic [FRACTION_BITS+1:0] mean_score;
	logic                     divisor_error;

	modport source (output valid, output mean_score, output divisor_error, input ready);
	modport sink (input valid, input mean_score, input divisor_error, output ready);
endinterface

`default_nettype wire

// File: hdl/mrdm_ratio.sv
`timescale 1ns / 1ps
`default_nettype none

module mrdm_ratio #(
	parameter int SAMPLE_WIDTH  = 32,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic signed [SAMPLE_WIDTH-1:0] ref_sample,
	input  wire logic signed [SAMPLE_WIDTH-1:0] eval_sample,
	output logic                                done,
	output logic [FRACTION_BITS+1:0]            ratio
);
	import mrdm_pkg::*;

	localparam int SW   = SAMPLE_WIDTH;
	localparam int RW   = FRACTION_BITS + 2;
	localparam int CNTW = $clog2(RW);

	typedef enum logic [3:0] {
		R_IDLE = 4'b0001,
		R_MAG  = 4'b0010,
		R_MAX  = 4'b0100,
		R_DIV  = 4'b1000
	} rat_state_t;

	rat_state_t             state_q;
	logic [CNTW-1:0]        cnt_q;
	logic signed [SW-1:0]   ref_q;
	logic signed [SW-1:0]   eval_q;
	logic [SW-1:0]          mag_ref_q;
	logic [SW-1:0]          mag_eval_q;
	logic [SW-1:0]          diff_q;
	logic [SW:0]            rem_q;
	logic [SW:0]            den_q;
	logic                   zero_q;
	logic [RW-1:0]          quot_q;
	logic                   done_q;

	logic signed [SW:0]     ref_ext;
	logic signed [SW:0]     eval_ext;
	logic signed [SW:0]     diff_ext;
	logic [SW:0]            neg_ref;
	logic [SW:0]            neg_eval;
	logic [SW:0]            neg_diff;
	logic [SW-1:0]          mag_max;
	logic                   ge;
	logic [SW:0]            rem_sub;

	always_comb begin
		ref_ext  = {ref_q[SW-1], ref_q};
		eval_ext = {eval_q[SW-1], eval_q};
		diff_ext = eval_ext - ref_ext;
		neg_ref  = -ref_ext;
		neg_eval = -eval_ext;
		neg_diff = -diff_ext;
		mag_max  = (mag_ref_q > mag_eval_q) ? mag_ref_q : mag_eval_q;
		ge       = (rem_q >= den_q);
		rem_sub  = ge ? (rem_q - den_q) : rem_q;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			R_IDLE: begin
				if (start) begin
					ref_q  <= ref_sample;
					eval_q <= eval_sample;
				end
			end
			R_MAG: begin
				mag_ref_q  <= ref_q[SW-1] ? neg_ref[SW-1:0] : ref_q;
				mag_eval_q <= eval_q[SW-1] ? neg_eval[SW-1:0] : eval_q;
				diff_q     <= diff_ext[SW] ? neg_diff[SW-1:0] : diff_ext[SW-1:0];
			end
			R_MAX: begin
				rem_q  <= {1'b0, diff_q};
				den_q  <= {mag_max, 1'b0};
				zero_q <= (mag_max == '0);
			end
			R_DIV: begin
				rem_q  <= {rem_sub[SW-1:0], 1'b0};
				quot_q <= {quot_q[RW-2:0], ge & ~zero_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				R_IDLE: begin
					if (start) begin
						state_q <= R_MAG;
					end
				end
				R_MAG: begin
					state_q <= R_MAX;
				end
				R_MAX: begin
					state_q <= R_DIV;
					cnt_q   <= CNTW'(RW - 1);
				end
				R_DIV: begin
					if (cnt_q == '0) begin
						state_q <= R_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: begin
					state_q <= R_IDLE;
				end
			endcase
		end
	end

	assign done  = done_q;
	assign ratio = quot_q;

endmodule

`default_nettype wire

// File: hdl/mrdm_mean.sv
`timescale 1ns / 1ps
`default_nettype none

module mrdm_mean #(
	parameter int FRACTION_BITS = 16,
	parameter int COUNT_WIDTH   = 20
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire mrdm_pkg::mrdm_cmd_t        cmd,
	input  wire logic [FRACTION_BITS+1:0]   ratio,
	input  wire logic [COUNT_WIDTH:0]       total_elements,
	output mrdm_pkg::mrdm_stat_t            stat,
	output logic [FRACTION_BITS+1:0]        mean
);
	import mrdm_pkg::*;

	localparam int RW    = FRACTION_BITS + 2;
	localparam int CW    = COUNT_WIDTH;
	localparam int SUM_W = COUNT_WIDTH + FRACTION_BITS + 2;
	localparam int CNTW  = $clog2(SUM_W);
	localparam logic [RW-1:0] TOP = {2'b10, {FRACTION_BITS{1'b0}}};

	typedef enum logic [2:0] {
		M_IDLE = 3'b001,
		M_LOAD = 3'b010,
		M_DIV  = 3'b100
	} mean_state_t;

	mean_state_t        state_q;
	logic [CNTW-1:0]    cnt_q;
	logic [SUM_W-1:0]   sum_q;
	logic [SUM_W-1:0]   num_q;
	logic [CW:0]        rem_q;
	logic [RW-1:0]      quot_q;
	logic               ovf_q;
	logic [RW-1:0]      mean_q;
	logic               err_q;
	logic               done_q;

	logic [SUM_W:0]     acc;
	logic [CW+1:0]      trial;
	logic [CW+1:0]      den_ext;
	logic               ge;
	logic [CW+1:0]      trial_sub;
	logic [RW-1:0]      quot_next;
	logic               ovf_next;

	always_comb begin
		acc       = {1'b0, sum_q} + {{(SUM_W + 1 - RW){1'b0}}, ratio};
		trial     = {rem_q, num_q[SUM_W-1]};
		den_ext   = {1'b0, total_elements};
		ge        = (trial >= den_ext);
		trial_sub = trial - den_ext;
		quot_next = {quot_q[RW-2:0], ge};
		ovf_next  = ovf_q | quot_q[RW-1];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			M_LOAD: begin
				num_q  <= sum_q;
				rem_q  <= '0;
				quot_q <= '0;
				ovf_q  <= 1'b0;
				if (total_elements == '0) begin
					mean_q <= '0;
					err_q  <= 1'b1;
				end
			end
			M_DIV: begin
				num_q  <= {num_q[SUM_W-2:0], 1'b0};
				rem_q  <= ge ? trial_sub[CW:0] : trial[CW:0];
				quot_q <= quot_next;
				ovf_q  <= ovf_next;
				if (cnt_q == '0) begin
					mean_q <= (ovf_next || (quot_next > TOP)) ? TOP : quot_next;
					err_q  <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			cnt_q   <= '0;
			sum_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (cmd.add) begin
						sum_q <= acc[SUM_W] ? '1 : acc[SUM_W-1:0];
						if (cmd.last) begin
							state_q <= M_LOAD;
						end
					end
				end
				M_LOAD: begin
					sum_q <= '0;
					cnt_q <= CNTW'(SUM_W - 1);
					if (total_elements == '0) begin
						state_q <= M_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= M_DIV;
					end
				end
				M_DIV: begin
					if (cnt_q == '0) begin
						state_q <= M_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: begin
					state_q <= M_IDLE;
				end
			endcase
		end
	end

	assign stat.done  = done_q;
	assign stat.error = err_q;
	assign mean       = mean_q;

endmodule

`default_nettype wire

// File: hdl/mean_relative_difference_to_max.sv
// Mean relative difference to the maximum over a field of sample pairs.
//
// Input words arrive on in_ch: a reference sample, an evaluated sample and a
// last flag. Each word contributes |eval - ref| / max(|eval|, |ref|) as an
// unsigned Q2.16 ratio to a saturating running sum. The word flagged last
// also closes the field: the sum is divided by the element count held in the
// configuration register and the mean leaves on out_ch as one word, after
// which the sum starts again from zero. A zero count gives a zero score with
// divisor_error set.
// One word at a time is in flight. Once a word is accepted, ready stays low
// while the restoring ratio divider, which yields one quotient bit a cycle,
// forms its ratio and adds it to the sum. A last word then also waits for the
// division of the sum by the element count, or only for the zero-count check,
// before its result appears on out_ch. The result sits in an output register;
// a stalled receiver does not stop new input words, though a further last word
// waits for it.
// Reset clears the sum, sets the element count to one and empties the
// output register. The count is written through cfg_wr_en and cfg_wr_data;
// the user must write it only while idle; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module mean_relative_difference_to_max #(
	parameter int SAMPLE_WIDTH  = mrdm_pkg::SAMPLE_WIDTH_DEF,
	parameter int FRACTION_BITS = mrdm_pkg::FRACTION_BITS_DEF,
	parameter int COUNT_WIDTH   = mrdm_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [COUNT_WIDTH:0] cfg_wr_data,
	mrdm_in_if.sink                 in_ch,
	mrdm_out_if.source              out_ch
);
	import mrdm_pkg::*;

	localparam int RW = FRACTION_BITS + 2;

	typedef enum logic [3:0] {
		T_IDLE  = 4'b0001,
		T_RATIO = 4'b0010,
		T_MEAN  = 4'b0100,
		T_PUSH  = 4'b1000
	} top_state_t;

	top_state_t         state_q;
	logic [COUNT_WIDTH:0] total_q;
	logic               last_q;
	logic               out_valid_q;
	logic [RW-1:0]      out_mean_q;
	logic               out_err_q;

	logic               accept;
	logic               ratio_done;
	logic [RW-1:0]      ratio;
	mrdm_cmd_t          cmd;
	mrdm_stat_t         stat;
	logic [RW-1:0]      mean;
	logic               out_free;
	logic               load_out;

	assign accept   = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;
	assign load_out = (state_q == T_PUSH) && out_free;
	assign cmd.add  = (state_q == T_RATIO) && ratio_done;
	assign cmd.last = last_q;

	mrdm_ratio #(
		.SAMPLE_WIDTH  (SAMPLE_WIDTH),
		.FRACTION_BITS (FRACTION_BITS)
	) u_ratio (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (accept),
		.ref_sample  (in_ch.ref_sample),
		.eval_sample (in_ch.eval_sample),
		.done        (ratio_done),
		.ratio       (ratio)
	);

	mrdm_mean #(
		.FRACTION_BITS (FRACTION_BITS),
		.COUNT_WIDTH   (COUNT_WIDTH)
	) u_mean (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.ratio          (ratio),
		.total_elements (total_q),
		.stat           (stat),
		.mean           (mean)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			last_q <= in_ch.last_item;
		end
		if (load_out) begin
			out_mean_q <= mean;
			out_err_q  <= stat.error;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			total_q     <= (COUNT_WIDTH + 1)'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				total_q <= cfg_wr_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						state_q <= T_RATIO;
					end
				end
				T_RATIO: begin
					if (ratio_done) begin
						state_q <= last_q ? T_MEAN : T_IDLE;
					end
				end
				T_MEAN: begin
					if (stat.done) begin
						state_q <= T_PUSH;
					end
				end
				T_PUSH: begin
					if (out_free) begin
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	assign in_ch.ready          = (state_q == T_IDLE);
	assign out_ch.valid         = out_valid_q;
	assign out_ch.mean_score    = out_mean_q;
	assign out_ch.divisor_error = out_err_q;

endmodule

`default_nettype wire

// File: hdl/mrdm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mrdm_checker #(
	parameter int FRACTION_BITS = mrdm_pkg::FRACTION_BITS_DEF
) (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     in_valid,
	input wire logic                     in_ready,
	input wire logic                     out_valid,
	input wire logic                     out_ready,
	input wire logic [FRACTION_BITS+1:0] mean_score,
	input wire logic                     divisor_error
);
	import mrdm_pkg::*;

	localparam logic [FRACTION_BITS+1:0] TOP = {2'b10, {FRACTION_BITS{1'b0}}};

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mean_score) && $stable(divisor_error))
		else $error("Output word changed while stalled.");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divisor_error |-> mean_score == '0)
		else $error("Divisor error with a non-zero score.");

	a_mean_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> mean_score <= TOP)
		else $error("Mean score above two.");

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Second input word taken while one is in flight.");

endmodule

bind mean_relative_difference_to_max mrdm_checker #(
	.FRACTION_BITS (FRACTION_BITS)
) u_mrdm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.mean_score    (out_ch.mean_score),
	.divisor_error (out_ch.divisor_error)
);

`default_nettype wire

// File: tb/mean_score_checker.sv
`timescale 1ns / 1ps

module mean_score_checker #(
	parameter int SW = mrdm_pkg::SAMPLE_WIDTH_DEF,
	parameter int FB = mrdm_pkg::FRACTION_BITS_DEF,
	parameter int CW = mrdm_pkg::COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [CW:0] cfg_wr_data,
	mrdm_in_if          in_ch,
	mrdm_out_if         out_ch,
	output int          mismatch_count,
	output int          pending_count
);

	localparam int SUM_W = CW + FB + 2;
	localparam longint SUM_MAX = (longint'(1) << SUM_W) - 1;
	localparam longint SCORE_CAP = longint'(2) << FB;

	typedef struct packed {
		logic [FB+1:0] score;
		logic          div_err;
	} field_mean_t;

	field_mean_t      expected_means[$];
	logic [CW:0]      element_count;
	logic [SUM_W-1:0] field_sum;

	function automatic logic [FB+1:0] pair_ratio(input logic signed [SW-1:0] r,
		input logic signed [SW-1:0] e);
		longint mag_r;
		longint mag_e;
		longint peak;
		longint gap;
		mag_r = (r < 0) ? -longint'(r) : longint'(r);
		mag_e = (e < 0) ? -longint'(e) : longint'(e);
		peak  = (mag_r > mag_e) ? mag_r : mag_e;
		gap   = longint'(e) - longint'(r);
		if (gap < 0)
			gap = -gap;
		if (peak == 0)
			return '0;
		return (FB + 2)'((gap << FB) / peak);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		field_mean_t want;
		longint      ratio;
		longint      mean;
		if (!arst_n) begin
			element_count = (CW + 1)'(1);
			field_sum = '0;
			expected_means.delete();
			pending_count <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_means.size() == 0) begin
					$error("result with no field closed: mean_score=%0d divisor_error=%0d",
						out_ch.mean_score, out_ch.divisor_error);
					mismatch_count++;
				end else begin
					want = expected_means.pop_front();
					if (out_ch.mean_score !== want.score) begin
						$error("mean_score: expected %0d, got %0d", want.score,
							out_ch.mean_score);
						mismatch_count++;
					end
					if (out_ch.divisor_error !== want.div_err) begin
						$error("divisor_error: expected %0d, got %0d", want.div_err,
							out_ch.divisor_error);
						mismatch_count++;
					end
				end
			end
			if (cfg_wr_en)
				element_count = cfg_wr_data;
			if (in_ch.valid && in_ch.ready) begin
				ratio = longint'(pair_ratio(in_ch.ref_sample, in_ch.eval_sample));
				if (ratio > SUM_MAX - longint'(field_sum))
					field_sum = '1;
				else
					field_sum = field_sum + SUM_W'(ratio);
				if (in_ch.last_item) begin
					if (element_count == 0) begin
						want.score = '0;
						want.div_err = 1'b1;
					end else begin
						mean = longint'(field_sum) / longint'(element_count);
						if (mean > SCORE_CAP)
							mean = SCORE_CAP;
						want.score = (FB + 2)'(mean);
						want.div_err = 1'b0;
					end
					expected_means.push_back(want);
					field_sum = '0;
				end
			end
			pending_count <= expected_means.size();
		end
	end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int SW = mrdm_pkg::SAMPLE_WIDTH_DEF;
	localparam int FB = mrdm_pkg::FRACTION_BITS_DEF;
	localparam int CW = mrdm_pkg::COUNT_WIDTH_DEF;
	localparam int SETTLE = 100;
	localparam int QUIET_LIMIT = 4000;
	localparam int PHASE_WORDS = 108;
	localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic signed [SW-1:0] S_MAX = ~S_MIN;
	localparam logic [CW:0] COUNT_FULL = (CW + 1)'(1) << CW;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [CW:0] cfg_wr_data;
	int          mismatch_count;
	int          pending_count;
	int          quiet_cycles;
	int          tx_idle_pct;
	int          rx_idle_pct;
	int          tx_burst;
	int          rx_burst;

	mrdm_in_if  #(.SAMPLE_WIDTH(SW))  in_ch();
	mrdm_out_if #(.FRACTION_BITS(FB)) out_ch();

	mean_relative_difference_to_max #(
		.SAMPLE_WIDTH(SW),
		.FRACTION_BITS(FB),
		.COUNT_WIDTH(CW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	mean_score_checker #(
		.SW(SW),
		.FB(FB),
		.CW(CW)
	) chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.mismatch_count(mismatch_count),
		.pending_count(pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (rx_burst > 0) begin
			rx_burst <= rx_burst - 1;
			out_ch.ready <= 1'b1;
		end else begin
			if ($urandom_range(63) == 0)
				rx_burst <= $urandom_range(10, 30);
			out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_wr_en || (in_ch.valid && in_ch.ready)
			|| (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_word(input logic signed [SW-1:0] r, input logic signed [SW-1:0] e,
		input logic last);
		if (tx_burst > 0) begin
			tx_burst--;
		end else if ($urandom_range(39) == 0) begin
			tx_burst = $urandom_range(10, 30);
		end else begin
			while ($urandom_range(99) < tx_idle_pct) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_ch.valid <= 1'b1;
		in_ch.ref_sample <= r;
		in_ch.eval_sample <= e;
		in_ch.last_item <= last;
		do
			@(posedge clk);
		while (!in_ch.ready);
	endtask

	// Lowers valid in the step of the final acceptance, then lets the block drain.
	task automatic drain_block();
		in_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_count != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_element_count(input logic [CW:0] value);
		drain_block();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic signed [SW-1:0] pick_sample();
		case ($urandom_range(7))
			0: return '0;
			1: return S_MIN;
			2: return S_MAX;
			3: return SW'($signed($urandom_range(600)) - 300);
			default: return SW'($urandom);
		endcase
	endfunction

	task automatic send_field(input int len);
		logic signed [SW-1:0] r;
		logic signed [SW-1:0] e;
		for (int i = 0; i < len; i++) begin
			r = pick_sample();
			case ($urandom_range(9))
				0: e = r;
				1: e = -r;
				2: e = r + SW'($signed($urandom_range(64)) - 32);
				3: begin
					r = '0;
					e = '0;
				end
				4: e = '0;
				default: e = pick_sample();
			endcase
			send_word(r, e, i == len - 1);
		end
	endtask

	task automatic run_phase(input logic [CW:0] count);
		int sent;
		int len;
		sent = 0;
		write_element_count(count);
		while (sent < PHASE_WORDS) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			send_field(len);
			sent += len;
		end
	endtask

	initial begin
		logic [CW:0] count;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_ch.valid = 1'b0;
		in_ch.ref_sample = '0;
		in_ch.eval_sample = '0;
		in_ch.last_item = 1'b0;
		out_ch.ready = 1'b0;
		tx_burst = 0;
		rx_burst = 0;
		tx_idle_pct = 11;
		rx_idle_pct = 58;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		write_element_count(1);
		send_word('0, '0, 1'b1);
		send_word(100, 100, 1'b1);
		send_word(S_MAX, S_MIN, 1'b1);
		send_word(S_MIN, S_MAX, 1'b1);
		send_word(S_MIN, S_MIN, 1'b1);
		send_word('0, S_MIN, 1'b1);
		send_word(S_MAX, '0, 1'b1);
		send_word(5, -5, 1'b1);
		send_word(-1, 1, 1'b0);
		send_word(1, -1, 1'b0);
		send_word(7, -7, 1'b1);
		send_word('0, '0, 1'b0);
		send_word(3, '0, 1'b1);
		send_word(1, 3, 1'b1);
		write_element_count(0);
		send_word(10, 20, 1'b0);
		send_word(10, 20, 1'b1);
		write_element_count(COUNT_FULL);
		send_word(S_MAX, S_MIN, 1'b0);
		send_word(S_MIN, S_MAX, 1'b1);
		write_element_count(3);
		send_word(S_MIN, S_MAX, 1'b0);
		send_word(-4, 4, 1'b0);
		send_word(9, 0, 1'b1);

		for (int mode = 0; mode < 3; mode++) begin
			tx_idle_pct = (mode == 0) ? 11 : (mode == 1) ? 58 : 0;
			rx_idle_pct = (mode == 0) ? 58 : (mode == 1) ? 11 : 0;
			for (int p = 0; p < 4; p++) begin
				case ((mode * 4 + p) % 5)
					0: count = (CW + 1)'($urandom_range(1, 8));
					1: count = '0;
					2: count = COUNT_FULL;
					3: count = (CW + 1)'(1);
					default: count = (CW + 1)'($urandom_range(0, 1 << CW));
				endcase
				run_phase(count);
			end
		end

		drain_block();
		if (mismatch_count == 0 && pending_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
